@@ hw/rtl/inm_pkg.sv @@
// ----------------------------------------------------------------------------
// inm_pkg
// Fixed-point constants and arithmetic helpers for the inverse normal sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package inm_pkg;

  localparam int DEF_UNIFORM_BITS = 32;

  // configuration register indexes
  localparam logic [1:0] REG_MEAN = 2'd0;
  localparam logic [1:0] REG_STD  = 2'd1;

  localparam longint unsigned SC = 64'd268435456;

  localparam logic signed [39:0] ONE_Q28 = 40'sd268435456;
  localparam logic [59:0] HALF_Q60    = 60'd576460752303423488;
  localparam logic [59:0] CENTRAL_LIM = 60'd484227031934875730;
  localparam logic [59:0] ZERO_REPL   = 60'd518814677;

  localparam logic signed [39:0] LN2_Q28 =
    40'((64'd6931471806 * SC + 64'd5000000000) / 64'd10000000000);

  localparam logic signed [39:0] NUM_C [4] = '{
    40'((64'd25066282388 * SC + 64'd5000000000) / 64'd10000000000),
    -40'((64'd18615000625 * SC + 64'd500000000) / 64'd1000000000),
    40'((64'd41391197735 * SC + 64'd500000000) / 64'd1000000000),
    -40'((64'd25441060496 * SC + 64'd500000000) / 64'd1000000000)
  };

  localparam logic signed [39:0] DEN_C [4] = '{
    -40'((64'd8473510931 * SC + 64'd500000000) / 64'd1000000000),
    40'((64'd23083367437 * SC + 64'd500000000) / 64'd1000000000),
    -40'((64'd21062241018 * SC + 64'd500000000) / 64'd1000000000),
    40'((64'd31308290983 * SC + 64'd5000000000) / 64'd10000000000)
  };

  localparam logic signed [39:0] TAIL_C [9] = '{
    40'((64'd33747548227 * SC + 64'd50000000000) / 64'd100000000000),
    40'((64'd9761690191 * SC + 64'd5000000000) / 64'd10000000000),
    40'((64'd16079797149 * SC + 64'd50000000000) / 64'd100000000000),
    40'((64'd27643881033 * SC + 64'd500000000000) / 64'd1000000000000),
    40'((64'd38405729374 * SC + 64'd5000000000000) / 64'd10000000000000),
    40'((64'd3951896512 * SC + 64'd5000000000000) / 64'd10000000000000),
    40'((64'd321767882 * SC + 64'd5000000000000) / 64'd10000000000000),
    40'((64'd2888167364 * SC + 64'd5000000000000000) / 64'd10000000000000000),
    40'((64'd3960315187 * SC + 64'd5000000000000000) / 64'd10000000000000000)
  };

  // One item's working set as it moves down the pipeline.
  typedef struct packed {
    logic [59:0]        u;
    logic               neg;
    logic               cen;
    logic               dz;
    logic               nsgn;
    logic [28:0]        y;
    logic [27:0]        rr;
    logic signed [39:0] nm;
    logic signed [39:0] dn;
    logic [63:0]        dd;
    logic [29:0]        q;
    logic [59:0]        tr;
    logic [5:0]         p;
    logic [30:0]        m;
    logic signed [6:0]  e;
    logic [27:0]        f;
    logic signed [39:0] rt;
    logic signed [39:0] xt;
    logic signed [39:0] x;
    logic signed [39:0] pr;
    logic [31:0]        sample;
    logic               err;
    logic               sat;
  } stage_t;

  // Q28 product, magnitude rounded half away from zero.
  function automatic logic signed [39:0] mul_q28(input logic signed [39:0] a,
                                                 input logic signed [39:0] b);
    logic [39:0] ma;
    logic [39:0] mb;
    logic [79:0] pp;
    logic [79:0] rp;
    ma = a[39] ? 40'(-a) : 40'(a);
    mb = b[39] ? 40'(-b) : 40'(b);
    pp = 80'(ma) * 80'(mb);
    rp = (pp + 80'd134217728) >> 28;
    mul_q28 = (a[39] ^ b[39]) ? -$signed(rp[39:0]) : $signed(rp[39:0]);
  endfunction

  function automatic logic [5:0] lead_one(input logic [59:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 60; i++) begin
      if (v[i]) pos = 6'(i);
    end
    lead_one = pos;
  endfunction

  function automatic logic [30:0] norm31(input logic [59:0] v, input logic [5:0] p);
    if (p >= 6'd30) norm31 = 31'(v >> (p - 6'd30));
    else norm31 = 31'(v << (6'd30 - p));
  endfunction

  // One log2 bit: square, renormalize. Returns {bit, mantissa}.
  function automatic logic [31:0] sq_step(input logic [30:0] m);
    logic [61:0] s;
    logic [31:0] t;
    s = 62'(m) * 62'(m);
    t = s[61:30];
    if (t[31]) sq_step = {1'b1, t[31:1]};
    else sq_step = {1'b0, t[30:0]};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/inverse_normal_moro.sv @@
// ----------------------------------------------------------------------------
// inverse_normal_moro
// Uniform U0.32 in, mean + std_dev * invnorm(u) out in Q16.16, saturated.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_*      | in  | tdata[31:0] uniform
//  m_*      | out | tdata[31:0] sample, [32] error, [33] saturated, [39:34] zero
//  cfg_*    | in  | index 0 mean, 1 std_dev; data Q16.16
//
//  One item per cycle while the output is not stalled. The depth is set by
//  the two bit-serial log2 chains of the tail (28 squaring stages each); the
//  30-stage restoring divider of the central region runs alongside them.
//  The whole pipeline holds while the output waits; the input stage still loads
//  when empty. Synchronous reset clears valid bits and mean, sets std_dev to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_normal_moro #(
  parameter int UNIFORM_BITS = inm_pkg::DEF_UNIFORM_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // uniform
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // sample[31:0], error, saturated, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import inm_pkg::*;

  localparam int SHIFT = 60 - UNIFORM_BITS;
  localparam logic [31:0] UMASK =
    (UNIFORM_BITS >= 32) ? 32'hFFFFFFFF : 32'((64'd1 << UNIFORM_BITS) - 64'd1);

  localparam int ST_A    = 1;
  localparam int ST_B    = 2;
  localparam int ST_HC   = 3;   // central Horner, four stages
  localparam int ST_N1   = 3;   // first normalize
  localparam int ST_SQ1  = 4;   // 28 squaring stages
  localparam int ST_NUM  = 7;
  localparam int ST_DIV  = 8;   // 30 divider stages
  localparam int ST_DEND = 37;
  localparam int ST_L1   = 32;
  localparam int ST_P2   = 33;
  localparam int ST_N2   = 34;
  localparam int ST_SQ2  = 35;
  localparam int ST_R2   = 63;
  localparam int ST_HT   = 64;  // tail Horner, eight stages
  localparam int ST_X    = 72;
  localparam int ST_MUL  = 73;
  localparam int ST_OUT  = 74;
  localparam int NST     = 75;

  logic signed [31:0] mean;
  logic signed [31:0] std_dev;

  stage_t        pipe [NST];
  stage_t        nxt  [NST];
  logic [NST-1:0] v;
  logic          advance;
  logic          load0;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= '0;
      std_dev <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MEAN) mean <= cfg_data;
      else if (cfg_index == REG_STD) std_dev <= cfg_data;
    end
  end

  assign advance  = !v[NST-1] || m_tready;
  assign load0    = advance || !v[0];
  assign s_tready = load0;

  always_comb begin
    nxt[0]   = '0;
    nxt[0].u = 60'(s_tdata & UMASK) << SHIFT;
  end

  for (genvar i = 1; i < NST; i++) begin : g_st
    // coefficient and bit positions of this stage, zero where unused
    localparam int HC_K = (i >= ST_HC && i < ST_HC + 3) ? 2 - (i - ST_HC) : 0;
    localparam int SQ_B = (i >= ST_SQ1 && i < ST_SQ1 + 28) ? 27 - (i - ST_SQ1) :
                          (i >= ST_SQ2 && i < ST_SQ2 + 28) ? 27 - (i - ST_SQ2) : 0;
    localparam int DV_B = (i >= ST_DIV && i <= ST_DEND) ? ST_DEND - i : 0;
    localparam int HT_K = (i >= ST_HT && i < ST_HT + 8) ? 7 - (i - ST_HT) : 0;

    always_comb begin
      stage_t             n;
      stage_t             c;
      logic [59:0]        ay;
      logic [31:0]        sq;
      logic signed [39:0] nmul;
      logic [39:0]        nmag;
      logic [63:0]        dsh;
      logic signed [39:0] xc;
      logic signed [40:0] sum;
      c    = pipe[i-1];
      n    = c;
      ay   = '0;
      sq   = '0;
      nmul = '0;
      nmag = '0;
      dsh  = '0;
      xc   = '0;
      sum  = '0;
      if (i == ST_A) begin
        n.neg = c.u < HALF_Q60;
        ay    = n.neg ? HALF_Q60 - c.u : c.u - HALF_Q60;
        n.cen = ay < CENTRAL_LIM;
        n.y   = 29'(({1'b0, ay} + 61'd2147483648) >> 32);
        n.tr  = n.neg ? c.u : 60'((61'd1 << 60) - {1'b0, c.u});
        if (n.tr == '0) n.tr = ZERO_REPL;
        n.nm  = NUM_C[3];
        n.dn  = DEN_C[3];
      end
      if (i == ST_B) begin
        n.rr = 28'(mul_q28($signed({11'b0, c.y}), $signed({11'b0, c.y})));
        n.p  = lead_one(c.tr);
      end
      if (i >= ST_HC && i < ST_HC + 3) begin
        n.nm = NUM_C[HC_K] + mul_q28(c.nm, $signed({12'b0, c.rr}));
        n.dn = DEN_C[HC_K] + mul_q28(c.dn, $signed({12'b0, c.rr}));
      end
      if (i == ST_HC + 3) begin
        n.dn = ONE_Q28 + mul_q28(c.dn, $signed({12'b0, c.rr}));
      end
      if (i == ST_N1) begin
        n.m = norm31(c.tr, c.p);
        n.e = $signed({1'b0, c.p}) - 7'sd60;
        n.f = '0;
      end
      if ((i >= ST_SQ1 && i < ST_SQ1 + 28) || (i >= ST_SQ2 && i < ST_SQ2 + 28)) begin
        sq  = sq_step(c.m);
        n.m = sq[30:0];
        n.f[SQ_B] = sq[31];
      end
      if (i == ST_NUM) begin
        nmul   = mul_q28($signed({11'b0, c.y}), c.nm);
        n.nsgn = nmul[39];
        nmag   = nmul[39] ? 40'(-nmul) : 40'(nmul);
        n.dz   = c.dn <= 40'sd0;
        n.dd   = {nmag[35:0], 28'b0} + {25'b0, c.dn[39:1]};
        n.q    = '0;
      end
      if (i >= ST_DIV && i <= ST_DEND) begin
        dsh = {24'b0, c.dn} << DV_B;
        if (c.dd >= dsh) begin
          n.dd = c.dd - dsh;
          n.q[DV_B] = 1'b1;
        end
      end
      if (i == ST_L1) begin
        // l1 = -ln(r), positive in the tail
        n.tr = {20'b0, 40'(-mul_q28($signed({{5{c.e[6]}}, c.e, c.f}), LN2_Q28))};
      end
      if (i == ST_P2) n.p = lead_one(c.tr);
      if (i == ST_N2) begin
        n.m = norm31(c.tr, c.p);
        n.e = $signed({1'b0, c.p}) - 7'sd28;
        n.f = '0;
      end
      if (i == ST_R2) begin
        n.rt = mul_q28($signed({{5{c.e[6]}}, c.e, c.f}), LN2_Q28);
        n.xt = TAIL_C[8];
      end
      if (i >= ST_HT && i < ST_HT + 8) begin
        n.xt = TAIL_C[HT_K] + mul_q28(c.rt, c.xt);
      end
      if (i == ST_X) begin
        if (c.cen) begin
          if (c.dz) xc = '0;
          else xc = c.nsgn ? -$signed({10'b0, c.q}) : $signed({10'b0, c.q});
        end else begin
          xc = c.xt;
        end
        n.x = c.neg ? -xc : xc;
      end
      if (i == ST_MUL) begin
        n.pr = mul_q28($signed({{8{std_dev[31]}}, std_dev}), c.x);
      end
      if (i == ST_OUT) begin
        sum = $signed({{9{mean[31]}}, mean}) + $signed({c.pr[39], c.pr});
        n.err = 1'b0;
        n.sat = 1'b0;
        if (std_dev[31]) begin
          n.sample = '0;
          n.err    = 1'b1;
        end else if (sum > 41'sd2147483647) begin
          n.sample = 32'h7FFFFFFF;
          n.sat    = 1'b1;
        end else if (sum < -41'sd2147483648) begin
          n.sample = 32'h80000000;
          n.sat    = 1'b1;
        end else begin
          n.sample = sum[31:0];
        end
      end
      nxt[i] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load0) v[0] <= s_tvalid;
      if (advance) v[NST-1:1] <= v[NST-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load0) pipe[0] <= nxt[0];
    if (advance) begin
      for (int k = 1; k < NST; k++) pipe[k] <= nxt[k];
    end
  end

  assign m_tvalid = v[NST-1];
  assign m_tdata  = {6'b0, pipe[NST-1].sat, pipe[NST-1].err, pipe[NST-1].sample};

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && !m_tdata[33])
    else $error("error result with nonzero sample or saturation");
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |->
      m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000)
    else $error("saturated result not at a rail");
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && v[0])
    else $error("input held off without an output stall");
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v[NST-1:1]))
    else $error("pipeline valid bits moved during a stall");
`endif

endmodule

`default_nettype wire
